>>> rtl/olist_pkg.sv
package olist_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ACT_INS_FRONT = 4'd0,
        ACT_INS_AFTER = 4'd1,
        ACT_INS_BACK  = 4'd2,
        ACT_DEL_FRONT = 4'd3,
        ACT_DEL_KEY   = 4'd4,
        ACT_DEL_BACK  = 4'd5,
        ACT_SEARCH    = 4'd6,
        ACT_COUNT     = 4'd7,
        ACT_SUM       = 4'd8,
        ACT_DUMP      = 4'd9
    } action_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOKEY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
        logic [6:0]         position;
        logic [6:0]         count;
        logic               last;
    } res_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   pos;
        logic signed [31:0] value;
    } cell_cmd_t;

endpackage

>>> rtl/olist_cell.sv
module olist_cell
    import olist_pkg::*;
(
    input  logic               clk,
    input  cell_cmd_t          cmd,
    input  logic [IDX_W-1:0]   idx,
    input  logic signed [31:0] prev_val,
    input  logic signed [31:0] next_val,
    output logic signed [31:0] val
);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (cmd.op)
            CELL_ROTATE:
            begin
                val_next = next_val;
            end
            CELL_INSERT:
            begin
                if (idx == cmd.pos)
                begin
                    val_next = cmd.value;
                end
                else if (idx > cmd.pos)
                begin
                    val_next = prev_val;
                end
            end
            CELL_DELETE:
            begin
                if (idx >= cmd.pos)
                begin
                    val_next = next_val;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

>>> rtl/olist_ctrl.sv
module olist_ctrl
    import olist_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  req_t               req,
    input  logic signed [31:0] head_val,
    output logic               busy,
    output logic               done,
    output res_t               result,
    output cell_cmd_t          cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [3:0]         act_reg, act_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] val_reg, val_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   fpos_reg, fpos_next;
    logic               pend_valid_reg, pend_valid_next;
    logic signed [31:0] pend_val_reg, pend_val_next;
    logic [IDX_W-1:0]   pend_pos_reg, pend_pos_next;
    logic signed [31:0] acc_reg, acc_next;
    logic               done_reg, done_next;
    res_t               res_reg, res_next;

    logic               full;
    logic               empty;
    logic               in_range;
    logic               match;
    logic [6:0]         len7;

    function automatic res_t make_res(input logic [1:0] st, input logic signed [31:0] v,
                                      input logic [6:0] pos, input logic [6:0] cnt,
                                      input logic lst);
        res_t r;
        r.status       = st;
        r.result_value = v;
        r.position     = pos;
        r.count        = cnt;
        r.last         = lst;
        return r;
    endfunction

    assign full     = (len_reg == LEN_W'(CAPACITY));
    assign empty    = (len_reg == '0);
    assign len7     = 7'(len_reg);
    assign in_range = (LEN_W'(step_reg) < len_reg);
    assign match    = in_range && (head_val == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        step_next       = step_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        found_next      = found_reg;
        fpos_next       = fpos_reg;
        pend_valid_next = pend_valid_reg;
        pend_val_next   = pend_val_reg;
        pend_pos_next   = pend_pos_reg;
        acc_next        = acc_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        cmd.op          = CELL_HOLD;
        cmd.pos         = '0;
        cmd.value       = req.value;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    res_next  = make_res(ST_OK, '0, '0, len7, 1'b1);
                    case (req.action)
                        ACT_INS_FRONT:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.op         = CELL_INSERT;
                                cmd.pos        = '0;
                                len_next       = len_reg + LEN_W'(1);
                                res_next.count = len7 + 7'd1;
                            end
                        end
                        ACT_INS_BACK:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.op            = CELL_INSERT;
                                cmd.pos           = len_reg[IDX_W-1:0];
                                len_next          = len_reg + LEN_W'(1);
                                res_next.position = len7;
                                res_next.count    = len7 + 7'd1;
                            end
                        end
                        ACT_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op         = CELL_DELETE;
                                cmd.pos        = '0;
                                len_next       = len_reg - LEN_W'(1);
                                res_next.count = len7 - 7'd1;
                            end
                        end
                        ACT_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                len_next          = len_reg - LEN_W'(1);
                                res_next.position = len7 - 7'd1;
                                res_next.count    = len7 - 7'd1;
                            end
                        end
                        ACT_INS_AFTER, ACT_DEL_KEY, ACT_SEARCH, ACT_DUMP, ACT_SUM:
                        begin
                            if (empty)
                            begin
                                if (req.action != ACT_SUM)
                                begin
                                    res_next.status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                done_next       = 1'b0;
                                state_next      = S_SCAN;
                                act_next        = req.action;
                                key_next        = req.key;
                                val_next        = req.value;
                                step_next       = '0;
                                found_next      = 1'b0;
                                pend_valid_next = 1'b0;
                                acc_next        = '0;
                            end
                        end
                        default:
                        begin
                            res_next = make_res(ST_OK, '0, '0, len7, 1'b1);
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.op = CELL_ROTATE;
                case (act_reg)
                    ACT_SEARCH:
                    begin
                        if (match)
                        begin
                            if (pend_valid_reg)
                            begin
                                done_next = 1'b1;
                                res_next  = make_res(ST_OK, pend_val_reg, 7'(pend_pos_reg),
                                                     len7, 1'b0);
                            end
                            pend_valid_next = 1'b1;
                            pend_val_next   = head_val;
                            pend_pos_next   = step_reg;
                        end
                    end
                    ACT_DUMP:
                    begin
                        if (in_range)
                        begin
                            done_next = 1'b1;
                            res_next  = make_res(ST_OK, head_val, 7'(step_reg), len7,
                                                 (LEN_W'(step_reg) + LEN_W'(1)) == len_reg);
                        end
                    end
                    ACT_SUM:
                    begin
                        if (in_range)
                        begin
                            acc_next = acc_reg + head_val;
                        end
                    end
                    ACT_INS_AFTER, ACT_DEL_KEY:
                    begin
                        if (match && !found_reg)
                        begin
                            found_next = 1'b1;
                            fpos_next  = step_reg;
                        end
                    end
                    default:
                    begin
                        found_next = found_reg;
                    end
                endcase
                if (step_reg == IDX_W'(CAPACITY - 1))
                begin
                    step_next  = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
                cmd.value  = val_reg;
                res_next   = make_res(ST_OK, '0, '0, len7, 1'b1);
                case (act_reg)
                    ACT_SEARCH:
                    begin
                        done_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            res_next = make_res(ST_OK, pend_val_reg, 7'(pend_pos_reg),
                                                len7, 1'b1);
                        end
                        else
                        begin
                            res_next.status = ST_NOKEY;
                        end
                    end
                    ACT_SUM:
                    begin
                        done_next             = 1'b1;
                        res_next.result_value = acc_reg;
                    end
                    ACT_INS_AFTER:
                    begin
                        done_next = 1'b1;
                        if (!found_reg)
                        begin
                            res_next.status = ST_NOKEY;
                        end
                        else if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.op            = CELL_INSERT;
                            cmd.pos           = fpos_reg + IDX_W'(1);
                            len_next          = len_reg + LEN_W'(1);
                            res_next.position = 7'(fpos_reg) + 7'd1;
                            res_next.count    = len7 + 7'd1;
                        end
                    end
                    ACT_DEL_KEY:
                    begin
                        done_next = 1'b1;
                        if (!found_reg)
                        begin
                            res_next.status = ST_NOKEY;
                        end
                        else
                        begin
                            cmd.op            = CELL_DELETE;
                            cmd.pos           = fpos_reg;
                            len_next          = len_reg - LEN_W'(1);
                            res_next.position = 7'(fpos_reg);
                            res_next.count    = len7 - 7'd1;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            step_reg       <= '0;
            act_reg        <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            found_reg      <= 1'b0;
            fpos_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_val_reg   <= '0;
            pend_pos_reg   <= '0;
            acc_reg        <= '0;
            done_reg       <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            step_reg       <= step_next;
            act_reg        <= act_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            found_reg      <= found_next;
            fpos_reg       <= fpos_next;
            pend_valid_reg <= pend_valid_next;
            pend_val_reg   <= pend_val_next;
            pend_pos_reg   <= pend_pos_next;
            acc_reg        <= acc_next;
            done_reg       <= done_next;
            res_reg        <= res_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/ordered_list_engine_top.sv
// channel   | ports                 | handshake
// ----------+-----------------------+------------------------------------------
// request   | start, busy, req      | taken at a rising edge with start && !busy
// result    | done, result          | one cycle per result, marked by done
//
// Front/back insert, front/back delete, count, sum of an empty list and any
// request that fails at once: answered in the next cycle, a new request may follow directly.
// Insert-after, delete-by-key, search, sum and dump on a non-empty list:
// the accept cycle, one full turn of the cell ring (one element past the
// head per cycle) and a closing cycle; busy is high for the turn and the
// closing cycle. Dump results stream out during the turn; search holds
// each match back one hit and gives its last result after the closing cycle.
// Reset clears the length and the control state; cell contents stay undefined.
// The receiver cannot stall: done is high for exactly one cycle per result.
module ordered_list_engine_top
    import olist_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output res_t result
);

    logic signed [31:0] cell_val [CAPACITY];
    cell_cmd_t          cmd;

    olist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .head_val (cell_val[0]),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cmd      (cmd)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        olist_cell u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .idx      (IDX_W'(i)),
            .prev_val (cell_val[(i + CAPACITY - 1) % CAPACITY]),
            .next_val (cell_val[(i + 1) % CAPACITY]),
            .val      (cell_val[i])
        );
    end

endmodule

>>> rtl/olist_checker.sv
module olist_checker
    import olist_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_EMPTY) |-> (result.count == 7'd0))
        else $error("empty status with non-zero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_FULL) |-> (result.count == 7'(CAPACITY)))
        else $error("full status below capacity");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |-> busy)
        else $error("request released before its final result");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(start && !busy) && !busy |-> done)
        else $error("one-cycle request gave no result");

endmodule

bind ordered_list_engine_top olist_checker u_chk (.*);
